/* hw/rtl/hrcd_pkg.sv */
// ----------------------------------------------------------------------------
// hrcd_pkg
// Types and constants shared by the request completeness detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hrcd_pkg;

   localparam int unsigned LenWidth  = 64;
   localparam int unsigned NameLen   = 15;
   localparam int unsigned MarkLen   = 4;

   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharVt    = 8'h0B;
   localparam logic [7:0] CharFf    = 8'h0C;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;

   localparam logic [LenWidth-1:0] MaxDiv10 = 64'd1844674407370955161;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_CLOSED = 2'd3
   } value_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic                complete;
      logic                headers_ended;
      logic [LenWidth-1:0] length_value;
   } rsp_type;

   // lower-case header name, one character per position
   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = 8'h63; // c
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h6C; // l
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/hrcd_if.sv */
// ----------------------------------------------------------------------------
// hrcd_req_if / hrcd_rsp_if
// Valid/ready channels carrying request bytes in and framing results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface hrcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        complete;
   logic        headers_ended;
   logic [63:0] length_value;

   modport source (output valid, output complete, output headers_ended,
                   output length_value, input ready);
   modport sink   (input valid, input complete, input headers_ended,
                   input length_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/http_request_completeness_detector_unit.sv */
// ----------------------------------------------------------------------------
// http_request_completeness_detector_unit
// Content-Length framing check over a stream of request bytes.
// ----------------------------------------------------------------------------
// req_if carries one request byte per transfer; first_byte starts a new
// buffer and clears all parsing state. rsp_if returns one result per byte:
// whether the headers have ended, the parsed content length so far, and
// whether the buffer up to this byte is a complete request.
// A byte passes an input register and then the matchers and parser, which
// write the result register. One byte is taken every cycle while rsp_if
// does not stall; the throughput is set by the parse step, which is
// combinational between the two registers and holds a 64-bit times-ten
// accumulate.
// When rsp_if stalls, the result register holds, the input register fills,
// and req_if.ready drops after at most one more transfer; nothing is lost.
// Reset empties both registers and returns the parser to the state of a new
// buffer, so bytes before any first_byte are parsed as a fresh request.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_completeness_detector_unit (
   input wire logic    clock,
   input wire logic    reset,
   hrcd_req_if.sink    req_if,
   hrcd_rsp_if.source  rsp_if
);
   import hrcd_pkg::*;

   req_type req_data;
   req_type stage_data;
   rsp_type rsp_data;
   logic    stage_valid;
   logic    stage_take;

   assign req_data.data_byte  = req_if.data_byte;
   assign req_data.first_byte = req_if.first_byte;

   hrcd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_data),
      .out_valid (stage_valid),
      .out_take  (stage_take),
      .out_data  (stage_data)
   );

   hrcd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_take   (stage_take),
      .in_data   (stage_data),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.complete      = rsp_data.complete;
   assign rsp_if.headers_ended = rsp_data.headers_ended;
   assign rsp_if.length_value  = rsp_data.length_value;

endmodule

`default_nettype wire

/* hw/rtl/hrcd_in_reg.sv */
// ----------------------------------------------------------------------------
// hrcd_in_reg
// Input register stage; holds one request byte until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcd_in_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire hrcd_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_take,
   output hrcd_pkg::req_type     out_data
);
   import hrcd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = in_valid ? 1'b1 : (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/hrcd_core.sv */
// ----------------------------------------------------------------------------
// hrcd_core
// Blank-line and header-name matchers, length parser, body counter and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcd_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_take,
   input  wire hrcd_pkg::req_type in_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hrcd_pkg::rsp_type      rsp_data
);
   import hrcd_pkg::*;

   // state registers
   logic [1:0]          blank_match_ff, blank_match_in;
   logic                header_done_ff, header_done_in;
   logic [3:0]          name_pos_ff, name_pos_in;
   logic                name_found_ff, name_found_in;
   value_phase_type     phase_ff, phase_in;
   logic                pending_cr_ff, pending_cr_in;
   logic                negative_ff, negative_in;
   logic                overflow_ff, overflow_in;
   logic [LenWidth-1:0] acc_ff, acc_in;
   logic [LenWidth-1:0] body_ff, body_in;
   logic [LenWidth-1:0] length_ff, length_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   // state as seen by this byte, cleared on a new buffer
   logic [1:0]          blank_match_s;
   logic                header_done_s;
   logic [3:0]          name_pos_s;
   logic                name_found_s;
   value_phase_type     phase_s;
   logic                pending_cr_s;
   logic                negative_s;
   logic                overflow_s;
   logic [LenWidth-1:0] acc_s;
   logic [LenWidth-1:0] body_s;
   logic [LenWidth-1:0] length_s;

   logic [7:0]          b;
   logic [7:0]          low;
   logic                is_digit;
   logic                is_space;
   logic                is_sign;
   logic                value_active;
   logic                take_digit;
   logic                set_sign;
   logic [3:0]          digit;
   logic [LenWidth-1:0] acc_times10;
   logic                digit_overflows;
   logic [3:0]          name_pos_inc;
   logic [2:0]          blank_inc;

   assign in_take   = in_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (in_data.first_byte) begin
         blank_match_s = '0;
         header_done_s = 1'b0;
         name_pos_s    = '0;
         name_found_s  = 1'b0;
         phase_s       = PH_SKIP;
         pending_cr_s  = 1'b0;
         negative_s    = 1'b0;
         overflow_s    = 1'b0;
         acc_s         = '0;
         body_s        = '0;
         length_s      = '0;
      end else begin
         blank_match_s = blank_match_ff;
         header_done_s = header_done_ff;
         name_pos_s    = name_pos_ff;
         name_found_s  = name_found_ff;
         phase_s       = phase_ff;
         pending_cr_s  = pending_cr_ff;
         negative_s    = negative_ff;
         overflow_s    = overflow_ff;
         acc_s         = acc_ff;
         body_s        = body_ff;
         length_s      = length_ff;
      end
   end

   // byte classes
   assign b        = in_data.data_byte;
   assign low      = (b >= CharUpA && b <= CharUpZ) ? (b + 8'd32) : b;
   assign is_digit = (b >= CharZero) && (b <= CharNine);
   assign is_space = (b == CharSpace) || (b == CharTab) || (b == CharLf) ||
                     (b == CharVt) || (b == CharFf) || (b == CharCr);
   assign is_sign  = (b == CharPlus) || (b == CharMinus);
   assign digit    = 4'(b - CharZero);

   assign value_active = !header_done_s && name_found_s;

   // value phase next state
   always_comb begin
      phase_in = phase_s;
      if (value_active) begin
         unique case (phase_s)
            PH_SKIP: begin
               if (pending_cr_s && b == CharLf) begin
                  phase_in = PH_CLOSED;
               end else if (is_space) begin
                  phase_in = PH_SKIP;
               end else if (is_sign) begin
                  phase_in = PH_SIGN;
               end else if (is_digit) begin
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_CLOSED;
               end
            end
            PH_SIGN, PH_DIGITS: begin
               phase_in = is_digit ? PH_DIGITS : PH_CLOSED;
            end
            PH_CLOSED: phase_in = PH_CLOSED;
            default:   phase_in = PH_CLOSED;
         endcase
      end
      if (!header_done_s && !name_found_s && name_pos_inc == 4'(NameLen)
          && low == name_char(name_pos_s)) begin
         phase_in = PH_SKIP;
      end
   end

   // value phase actions
   always_comb begin
      take_digit    = 1'b0;
      set_sign      = 1'b0;
      pending_cr_in = pending_cr_s;
      if (value_active) begin
         unique case (phase_s)
            PH_SKIP: begin
               if (pending_cr_s && b == CharLf) begin
                  pending_cr_in = 1'b0;
               end else begin
                  pending_cr_in = (b == CharCr);
                  set_sign      = !is_space && is_sign;
                  take_digit    = !is_space && !is_sign && is_digit;
               end
            end
            PH_SIGN, PH_DIGITS: take_digit = is_digit;
            PH_CLOSED: take_digit = 1'b0;
            default:   take_digit = 1'b0;
         endcase
      end
   end

   // digit accumulate
   assign acc_times10 = {acc_s[LenWidth-4:0], 3'b000} + {acc_s[LenWidth-2:0], 1'b0};
   assign digit_overflows = (acc_s > MaxDiv10) || (acc_s == MaxDiv10 && digit > 4'd5);

   always_comb begin
      negative_in = set_sign ? (b == CharMinus) : negative_s;
      overflow_in = overflow_s;
      acc_in      = acc_s;
      if (take_digit && !overflow_s) begin
         if (digit_overflows) begin
            overflow_in = 1'b1;
         end else begin
            acc_in = acc_times10 + {{(LenWidth-4){1'b0}}, digit};
         end
      end
      if (overflow_in) begin
         length_in = '0;
      end else if (negative_in) begin
         length_in = '0 - acc_in;
      end else begin
         length_in = acc_in;
      end
   end

   // header name matcher
   assign name_pos_inc = name_pos_s + 4'd1;

   always_comb begin
      name_pos_in   = name_pos_s;
      name_found_in = name_found_s;
      if (!header_done_s && !name_found_s) begin
         if (low == name_char(name_pos_s)) begin
            if (name_pos_inc == 4'(NameLen)) begin
               name_found_in = 1'b1;
               name_pos_in   = '0;
            end else begin
               name_pos_in = name_pos_inc;
            end
         end else begin
            name_pos_in = (low == name_char(4'd0)) ? 4'd1 : 4'd0;
         end
      end
   end

   // blank line matcher
   assign blank_inc = {1'b0, blank_match_s} + 3'd1;

   always_comb begin
      blank_match_in = blank_match_s;
      header_done_in = header_done_s;
      if (!header_done_s) begin
         if (b == (blank_match_s[0] ? CharLf : CharCr)) begin
            if (blank_inc == 3'(MarkLen)) begin
               header_done_in = 1'b1;
               blank_match_in = '0;
            end else begin
               blank_match_in = blank_inc[1:0];
            end
         end else begin
            blank_match_in = (b == CharCr) ? 2'd1 : 2'd0;
         end
      end
   end

   // body counter, length is frozen once the headers have ended
   always_comb begin
      body_in = body_s;
      if (header_done_s && body_s != {LenWidth{1'b1}}) begin
         body_in = body_s + 64'd1;
      end
      rsp_in.complete      = header_done_in && (body_in >= length_s);
      rsp_in.headers_ended = header_done_in;
      rsp_in.length_value  = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_match_ff <= '0;
         header_done_ff <= 1'b0;
         name_pos_ff    <= '0;
         name_found_ff  <= 1'b0;
         phase_ff       <= PH_SKIP;
         pending_cr_ff  <= 1'b0;
         negative_ff    <= 1'b0;
         overflow_ff    <= 1'b0;
         acc_ff         <= '0;
         body_ff        <= '0;
         length_ff      <= '0;
      end else if (in_take) begin
         blank_match_ff <= blank_match_in;
         header_done_ff <= header_done_in;
         name_pos_ff    <= name_pos_in;
         name_found_ff  <= name_found_in;
         phase_ff       <= phase_in;
         pending_cr_ff  <= pending_cr_in;
         negative_ff    <= negative_in;
         overflow_ff    <= overflow_in;
         acc_ff         <= acc_in;
         body_ff        <= body_in;
         length_ff      <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* tb/hrcd_framing_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrcd_framing_scoreboard
// Watches both channels of the completeness detector, keeps its own model of
// the header and Content-Length parser, and checks every result transfer
// against the framing predicted for the oldest byte still awaiting one.
// ----------------------------------------------------------------------------

module hrcd_framing_scoreboard (
   input  logic clock,
   input  logic reset,
   hrcd_req_if  req_tap,
   hrcd_rsp_if  rsp_tap,
   output int   mismatch_count,
   output int   awaited_count
);

   import hrcd_pkg::*;

   localparam logic [8*NameLen-1:0] HdrName = "content-length:";

   logic [1:0]      mark_pos;
   logic            blank_seen;
   logic [3:0]      name_pos;
   logic            name_seen;
   value_phase_type num_phase;
   logic            cr_held;
   logic            minus_seen;
   logic            too_big;
   logic [63:0]     digits_acc;
   logic [63:0]     body_bytes;

   rsp_type pending_framing[$];
   rsp_type want;
   int      fail_tally = 0;

   task automatic clear_parser();
      mark_pos   = '0;
      blank_seen = 1'b0;
      name_pos   = '0;
      name_seen  = 1'b0;
      num_phase  = PH_SKIP;
      cr_held    = 1'b0;
      minus_seen = 1'b0;
      too_big    = 1'b0;
      digits_acc = '0;
      body_bytes = '0;
   endtask

   task automatic take_digit(input logic [7:0] b);
      logic [63:0] d;
      d = {56'd0, b - CharZero};
      if (!too_big) begin
         if (digits_acc > MaxDiv10 || (digits_acc == MaxDiv10 && d > 64'd5)) begin
            too_big = 1'b1;
         end else begin
            digits_acc = digits_acc * 64'd10 + d;
         end
      end
   endtask

   task automatic frame_byte(input logic [7:0] b, input logic restart, output rsp_type res);
      logic [7:0]  low;
      logic [7:0]  mark_char;
      logic [3:0]  pos;
      logic [63:0] len;
      logic        is_dig;
      logic        is_ws;
      if (restart) clear_parser();
      is_dig = (b >= CharZero) && (b <= CharNine);
      is_ws  = (b == CharSpace) || (b == CharTab) || (b == CharLf) ||
               (b == CharVt) || (b == CharFf) || (b == CharCr);
      if (blank_seen) begin
         if (body_bytes != '1) body_bytes = body_bytes + 64'd1;
      end else begin
         if (name_seen) begin
            if (num_phase == PH_SKIP) begin
               if (cr_held && b == CharLf) begin
                  cr_held   = 1'b0;
                  num_phase = PH_CLOSED;
               end else if (b == CharCr) begin
                  cr_held = 1'b1;
               end else begin
                  cr_held = 1'b0;
                  if (b == CharPlus || b == CharMinus) begin
                     minus_seen = (b == CharMinus);
                     num_phase  = PH_SIGN;
                  end else if (is_dig) begin
                     take_digit(b);
                     num_phase = PH_DIGITS;
                  end else if (!is_ws) begin
                     num_phase = PH_CLOSED;
                  end
               end
            end else if (num_phase == PH_SIGN || num_phase == PH_DIGITS) begin
               if (is_dig) begin
                  take_digit(b);
                  num_phase = PH_DIGITS;
               end else begin
                  num_phase = PH_CLOSED;
               end
            end
         end else begin
            low = (b >= CharUpA && b <= CharUpZ) ? b + 8'd32 : b;
            pos = (name_pos < NameLen) ? name_pos : 4'd0;
            if (low == HdrName[8*(NameLen-1-pos) +: 8]) begin
               pos = pos + 4'd1;
               if (pos == NameLen) begin
                  name_seen = 1'b1;
                  num_phase = PH_SKIP;
                  pos       = 4'd0;
               end
            end else begin
               pos = (low == HdrName[8*(NameLen-1) +: 8]) ? 4'd1 : 4'd0;
            end
            name_pos = pos;
         end
         mark_char = mark_pos[0] ? CharLf : CharCr;
         if (b == mark_char) begin
            if (mark_pos == 2'd3) begin
               blank_seen = 1'b1;
               mark_pos   = 2'd0;
            end else begin
               mark_pos = mark_pos + 2'd1;
            end
         end else begin
            mark_pos = (b == CharCr) ? 2'd1 : 2'd0;
         end
      end
      len = too_big ? 64'd0 : (minus_seen ? 64'd0 - digits_acc : digits_acc);
      res.complete      = blank_seen && (body_bytes >= len);
      res.headers_ended = blank_seen;
      res.length_value  = len;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         pending_framing.delete();
      end else begin
         if (rsp_tap.valid && rsp_tap.ready) begin
            if (pending_framing.size() == 0) begin
               $display("%0t unexpected result: expected none, actual complete=%0b %s=%0b %s=%0d",
                        $time, rsp_tap.complete, "headers_ended", rsp_tap.headers_ended,
                        "length_value", rsp_tap.length_value);
               fail_tally++;
            end else begin
               want = pending_framing.pop_front();
               if (rsp_tap.complete !== want.complete) begin
                  $display("%0t complete mismatch: expected %0b, actual %0b",
                           $time, want.complete, rsp_tap.complete);
                  fail_tally++;
               end
               if (rsp_tap.headers_ended !== want.headers_ended) begin
                  $display("%0t headers_ended mismatch: expected %0b, actual %0b",
                           $time, want.headers_ended, rsp_tap.headers_ended);
                  fail_tally++;
               end
               if (rsp_tap.length_value !== want.length_value) begin
                  $display("%0t length_value mismatch: expected %0d, actual %0d",
                           $time, want.length_value, rsp_tap.length_value);
                  fail_tally++;
               end
            end
         end
         if (req_tap.valid && req_tap.ready) begin
            frame_byte(req_tap.data_byte, req_tap.first_byte, want);
            pending_framing.insert(pending_framing.size(), want);
         end
      end
      mismatch_count <= fail_tally;
      awaited_count  <= pending_framing.size();
   end

endmodule

/* tb/tb_http_request_completeness_detector_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_request_completeness_detector_unit
// Drives request buffers into the completeness detector: a few directed
// buffers, then random requests (well-formed with random content, broken and
// noise) under several idle and stall mixes, and reports the verdict.
// ----------------------------------------------------------------------------

module tb_http_request_completeness_detector_unit;

   import hrcd_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int PhaseItems    = 425;

   logic clock;
   logic reset;
   int   mismatch_total;
   int   awaited_total;
   int   quiet_cycles = 0;
   int   send_gap_pct = 0;
   int   recv_stall_pct = 0;

   logic [7:0] frame_bytes[$];

   hrcd_req_if req_if ();
   hrcd_rsp_if rsp_if ();

   http_request_completeness_detector_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   hrcd_framing_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tap        (req_if),
      .rsp_tap        (rsp_if),
      .mismatch_count (mismatch_total),
      .awaited_count  (awaited_total)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WatchdogLimit);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic put_byte(input logic [7:0] b);
      frame_bytes.insert(frame_bytes.size(), b);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_crlf();
      put_byte(CharCr);
      put_byte(CharLf);
   endtask

   task automatic put_filler();
      case ($urandom_range(3))
         0: put_text("Host: example");
         1: put_text("Accept: */*");
         2: begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(33, 126)));
            put_text(": v");
         end
         default: put_text("X-Len: 12");
      endcase
      put_crlf();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= b;
      req_if.first_byte <= first;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_frame(input logic restart);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], restart && (i == 0));
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int budget);
      int         sent;
      int         kind;
      int         hint;
      int         n;
      int         start;
      int         cut;
      logic [7:0] c;
      send_gap_pct = gap_pct;
      recv_stall_pct <= stall_pct;
      sent = 0;
      while (sent < budget) begin
         frame_bytes.delete();
         kind = $urandom_range(99);
         hint = $urandom_range(4);
         if (kind < 20) begin
            repeat ($urandom_range(1, 40)) begin
               case ($urandom_range(7))
                  0:       c = CharCr;
                  1:       c = CharLf;
                  default: c = 8'($urandom_range(255));
               endcase
               put_byte(c);
            end
         end else begin
            if ($urandom_range(1)) begin
               put_text("GET / HTTP/1.1");
               put_crlf();
            end
            repeat ($urandom_range(2)) put_filler();
            case ($urandom_range(5))
               0: begin
                  put_text("contentlength: 7");
                  put_crlf();
               end
               1: begin
                  put_text("Content-Lengt: 3");
                  put_crlf();
               end
               2: put_text("conten");
               3: put_text("c");
               default: ;
            endcase
            if ($urandom_range(9) != 0) begin
               start = frame_bytes.size();
               put_text("content-length:");
               for (int i = start; i < frame_bytes.size(); i++) begin
                  if (frame_bytes[i] >= "a" && frame_bytes[i] <= "z" && $urandom_range(1))
                     frame_bytes[i] = frame_bytes[i] - 8'd32;
               end
               repeat ($urandom_range(3)) begin
                  case ($urandom_range(7))
                     3:       c = CharTab;
                     4:       c = CharVt;
                     5:       c = CharFf;
                     6:       c = CharCr;
                     7:       c = CharLf;
                     default: c = CharSpace;
                  endcase
                  put_byte(c);
               end
               case ($urandom_range(9))
                  1: begin
                     hint = $urandom_range(30);
                     put_text("00");
                     put_text($sformatf("%0d", hint));
                  end
                  2: begin
                     n = $urandom_range(20);
                     if ($urandom_range(1)) begin
                        put_text("+");
                        hint = n;
                     end else begin
                        put_text("-");
                     end
                     put_text($sformatf("%0d", n));
                  end
                  3: begin
                     put_text($urandom_range(1) ? "+" : "-");
                     if ($urandom_range(1)) put_text("x");
                  end
                  4: ;
                  5: begin
                     case ($urandom_range(4))
                        0: put_text("18446744073709551615");
                        1: put_text("18446744073709551616");
                        2: put_text("18446744073709551619");
                        3: put_text("1844674407370955161");
                        default: put_text("99999999999999999999");
                     endcase
                  end
                  6: begin
                     put_byte(8'($urandom_range(CharZero + 1, CharNine)));
                     repeat ($urandom_range(19, 23))
                        put_byte(8'($urandom_range(CharZero, CharNine)));
                  end
                  7: put_text("abc");
                  default: begin
                     hint = $urandom_range(30);
                     put_text($sformatf("%0d", hint));
                  end
               endcase
               if ($urandom_range(3) == 0) put_text(" ;5");
               put_crlf();
               if ($urandom_range(4) == 0) begin
                  put_text("Content-Length: 2");
                  put_crlf();
               end
            end
            repeat ($urandom_range(2)) put_filler();
            put_crlf();
            n = hint + $urandom_range(3) - 1;
            if ($urandom_range(4) == 0) n = n + $urandom_range(10);
            repeat ((n < 0) ? 0 : n) put_byte(8'($urandom_range(255)));
            if (kind >= 90) begin
               cut = $urandom_range(1, frame_bytes.size());
               while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
         end
         send_frame($urandom_range(19) != 0);
         sent = sent + frame_bytes.size();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.data_byte  <= 8'd0;
      req_if.first_byte <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // bytes ahead of any buffer start, body extremes with no length
      frame_bytes.delete();
      put_crlf();
      put_crlf();
      put_byte(8'h00);
      put_byte(8'hFF);
      send_frame(1'b0);

      // upper-case name, negative length wraps to all ones
      frame_bytes.delete();
      put_text("CONTENT-LENGTH:-1");
      put_crlf();
      put_crlf();
      send_frame(1'b1);

      run_phase(0, 0, PhaseItems);
      run_phase(55, 0, PhaseItems);
      run_phase(0, 55, PhaseItems);
      run_phase(25, 25, PhaseItems);

      req_if.valid   <= 1'b0;
      recv_stall_pct <= 0;
      @(posedge clock);
      while (awaited_total != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
